// ===== design/pfc_pkg.sv =====
// Package for the pixel format converter: format codes, pixel types,
// the CGA palette and small helper functions.
// Used by every module of the converter; depends on nothing else.
package pfc_pkg;

    typedef enum logic [4:0] {
        FMT_Y1       = 5'd0,
        FMT_Y2       = 5'd1,
        FMT_Y4       = 5'd2,
        FMT_CGA4     = 5'd3,
        FMT_Y8       = 5'd4,
        FMT_BGR332   = 5'd5,
        FMT_Y16      = 5'd6,
        FMT_XRGB4444 = 5'd7,
        FMT_BGR565   = 5'd8,
        FMT_Y32      = 5'd9,
        FMT_RGBX     = 5'd10,
        FMT_BGRX     = 5'd11,
        FMT_XRGB     = 5'd12,
        FMT_XBGR     = 5'd13,
        FMT_Y24      = 5'd14,
        FMT_RGB      = 5'd15,
        FMT_BGR      = 5'd16
    } fmt_t;

    typedef enum logic {
        REG_SOURCE_FORMAT = 1'b0,
        REG_DEST_FORMAT   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba_t;

    localparam int PIXEL_W = 32;
    localparam int SUM_W   = 10;
    localparam int SCORE_W = 10;

    localparam logic [SUM_W-1:0]   Y1_THRESHOLD = 10'd384;
    localparam logic [2*SUM_W-1:0] RECIP_THIRD  = 20'd683;
    localparam int                 RECIP_SHIFT  = 11;

    localparam logic [23:0] CGA_PALETTE [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    function automatic rgba_t pfc_grey(input logic [7:0] y);
        return '{r: y, g: y, b: y, a: 8'hff};
    endfunction

    function automatic logic [PIXEL_W-1:0] fmt_mask(input fmt_t fmt);
        logic [PIXEL_W-1:0] m;
        unique case (fmt) inside
            FMT_Y1:                                   m = 32'h0000_0001;
            FMT_Y2:                                   m = 32'h0000_0003;
            FMT_Y4, FMT_CGA4:                         m = 32'h0000_000f;
            FMT_Y8, FMT_BGR332:                       m = 32'h0000_00ff;
            FMT_Y16, FMT_XRGB4444, FMT_BGR565:        m = 32'h0000_ffff;
            FMT_Y24, FMT_RGB, FMT_BGR:                m = 32'h00ff_ffff;
            FMT_Y32, FMT_RGBX, FMT_BGRX, FMT_XRGB,
            FMT_XBGR:                                 m = 32'hffff_ffff;
            default:                                  m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== design/pfc_to_rgba.sv =====
// Source side of the converter: unpacks a right-aligned source pixel into
// 32-bit RGBA, widening narrow channels by bit repetition.
// Depends on pfc_pkg.
module pfc_to_rgba (
    input  pfc_pkg::fmt_t  fmt,
    input  logic [31:0]    pixel,
    output pfc_pkg::rgba_t rgba
);
    import pfc_pkg::*;

    always_comb
    begin
        unique case (fmt) inside
            FMT_Y1:       rgba = pixel[0] ? 32'hffff_ffff : 32'h0000_00ff;
            FMT_Y2:       rgba = pfc_grey({4{pixel[1:0]}});
            FMT_Y4:       rgba = pfc_grey({2{pixel[3:0]}});
            FMT_CGA4:     rgba = {CGA_PALETTE[pixel[3:0]], 8'hff};
            FMT_Y8:       rgba = pfc_grey(pixel[7:0]);
            FMT_BGR332:   rgba = {{4{pixel[1:0]}},
                                  pixel[4:2], pixel[4:2], pixel[4:3],
                                  pixel[7:5], pixel[7:5], pixel[7:6], 8'hff};
            FMT_Y16:      rgba = pfc_grey(pixel[15:8]);
            FMT_XRGB4444: rgba = {{2{pixel[11:8]}}, {2{pixel[7:4]}},
                                  {2{pixel[3:0]}}, 8'hff};
            FMT_BGR565:   rgba = {pixel[4:0], pixel[4:2], pixel[10:5], pixel[10:9],
                                  pixel[15:11], pixel[15:13], 8'hff};
            FMT_Y32:      rgba = pfc_grey(pixel[31:24]);
            FMT_BGRX:     rgba = {pixel[15:8], pixel[23:16], pixel[31:24], 8'hff};
            FMT_XRGB, FMT_RGB:
                          rgba = {pixel[23:16], pixel[15:8], pixel[7:0], 8'hff};
            FMT_XBGR, FMT_BGR:
                          rgba = {pixel[7:0], pixel[15:8], pixel[23:16], 8'hff};
            FMT_Y24:      rgba = pfc_grey(pixel[23:16]);
            default:      rgba = pixel;
        endcase
    end

endmodule

// ===== design/pfc_cga_match.sv =====
// Finds the CGA palette entry nearest to an RGB color by L1 distance,
// the lowest index winning ties, through a four-level compare tree.
// Depends on pfc_pkg.
module pfc_cga_match (
    input  logic [7:0] r,
    input  logic [7:0] g,
    input  logic [7:0] b,
    output logic [3:0] index
);
    import pfc_pkg::*;

    function automatic logic [7:0] abs_diff(input logic [7:0] x, input logic [7:0] y);
        return (x > y) ? (x - y) : (y - x);
    endfunction

    logic [SCORE_W-1:0] score16 [16];
    logic [SCORE_W-1:0] score8  [8];
    logic [SCORE_W-1:0] score4  [4];
    logic [SCORE_W-1:0] score2  [2];
    logic [3:0]         idx8    [8];
    logic [3:0]         idx4    [4];
    logic [3:0]         idx2    [2];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            score16[i] = SCORE_W'(abs_diff(CGA_PALETTE[i][23:16], r))
                       + SCORE_W'(abs_diff(CGA_PALETTE[i][15:8], g))
                       + SCORE_W'(abs_diff(CGA_PALETTE[i][7:0], b));
        end
        // The right entry of a pair wins only when strictly closer.
        for (int i = 0; i < 8; i++)
        begin
            if (score16[2*i+1] < score16[2*i])
            begin
                score8[i] = score16[2*i+1];
                idx8[i]   = 4'(2*i+1);
            end
            else
            begin
                score8[i] = score16[2*i];
                idx8[i]   = 4'(2*i);
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            if (score8[2*i+1] < score8[2*i])
            begin
                score4[i] = score8[2*i+1];
                idx4[i]   = idx8[2*i+1];
            end
            else
            begin
                score4[i] = score8[2*i];
                idx4[i]   = idx8[2*i];
            end
        end
        for (int i = 0; i < 2; i++)
        begin
            if (score4[2*i+1] < score4[2*i])
            begin
                score2[i] = score4[2*i+1];
                idx2[i]   = idx4[2*i+1];
            end
            else
            begin
                score2[i] = score4[2*i];
                idx2[i]   = idx4[2*i];
            end
        end
        index = (score2[1] < score2[0]) ? idx2[1] : idx2[0];
    end

endmodule

// ===== design/pfc_from_rgba.sv =====
// Destination side of the converter: packs 32-bit RGBA into the
// destination format, with grey levels, CGA matching and channel packing.
// Depends on pfc_pkg and pfc_cga_match.
module pfc_from_rgba (
    input  pfc_pkg::fmt_t  fmt,
    input  pfc_pkg::rgba_t rgba,
    output logic [31:0]    pixel
);
    import pfc_pkg::*;

    logic [SUM_W-1:0]   sum;
    logic [2*SUM_W-1:0] product;
    logic [7:0]         luma;
    logic [3:0]         cga_index;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;

    assign r = rgba.r;
    assign g = rgba.g;
    assign b = rgba.b;

    // The sum is at most 765, so multiplying by 683/2048 gives the exact
    // quotient by three.
    assign sum     = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
    assign product = {{SUM_W{1'b0}}, sum} * RECIP_THIRD;
    assign luma    = product[RECIP_SHIFT+7:RECIP_SHIFT];

    pfc_cga_match u_cga_match (
        .r     (r),
        .g     (g),
        .b     (b),
        .index (cga_index)
    );

    always_comb
    begin
        unique case (fmt) inside
            FMT_Y1:       pixel = {31'd0, sum >= Y1_THRESHOLD};
            FMT_Y2:       pixel = {30'd0, luma[7:6]};
            FMT_Y4:       pixel = {28'd0, luma[7:4]};
            FMT_CGA4:     pixel = {28'd0, cga_index};
            FMT_Y8:       pixel = {24'd0, luma};
            FMT_BGR332:   pixel = {24'd0, b[7:5], g[7:5], r[7:6]};
            FMT_Y16:      pixel = {16'd0, luma, luma};
            FMT_XRGB4444: pixel = {16'd0, 4'hf, r[7:4], g[7:4], b[7:4]};
            FMT_BGR565:   pixel = {16'd0, b[7:3], g[7:2], r[7:3]};
            FMT_Y32:      pixel = {4{luma}};
            FMT_BGRX:     pixel = {b, g, r, 8'hff};
            FMT_XRGB, FMT_RGB:
                          pixel = {8'd0, r, g, b};
            FMT_XBGR, FMT_BGR:
                          pixel = {8'd0, b, g, r};
            FMT_Y24:      pixel = {8'd0, luma, luma, luma};
            default:      pixel = rgba;
        endcase
    end

endmodule

// ===== design/pixel_format_converter_top.sv =====
// Top level of the pixel format converter: stream ports, format registers,
// input register, conversion logic and output register.
// Depends on pfc_pkg, pfc_to_rgba and pfc_from_rgba.
// A word waits in the input register until the output register is free. Throughput:
// one word per cycle unless the output stalls; the input register and the output
// register each hold one word, so a stalled output still lets one more word in.
// Reset: rst_n clears both valid flags and sets both formats to 1-bit grey.
// The configuration port is always ready.
module pixel_format_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // src_pixel[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // dst_pixel[31:0]
);
    import pfc_pkg::*;

    fmt_t        src_fmt_reg;
    fmt_t        src_fmt_next;
    fmt_t        dst_fmt_reg;
    fmt_t        dst_fmt_next;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] in_pixel_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_pixel_reg;
    logic        advance;
    logic [31:0] src_masked;
    rgba_t       rgba;
    logic [31:0] packed_pixel;
    logic [31:0] result;

    assign cfg_ready     = 1'b1;
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pixel_reg;

    always_comb
    begin
        src_fmt_next = src_fmt_reg;
        dst_fmt_next = dst_fmt_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SOURCE_FORMAT: src_fmt_next = fmt_t'(cfg_data);
                REG_DEST_FORMAT:   dst_fmt_next = fmt_t'(cfg_data);
            endcase
        end
    end

    assign src_masked = in_pixel_reg & fmt_mask(src_fmt_reg);

    pfc_to_rgba u_to_rgba (
        .fmt   (src_fmt_reg),
        .pixel (src_masked),
        .rgba  (rgba)
    );

    pfc_from_rgba u_from_rgba (
        .fmt   (dst_fmt_reg),
        .rgba  (rgba),
        .pixel (packed_pixel)
    );

    always_comb
    begin
        if (src_fmt_reg > FMT_BGR || dst_fmt_reg > FMT_BGR)
        begin
            result = '0;
        end
        else if (src_fmt_reg == dst_fmt_reg)
        begin
            result = src_masked & fmt_mask(dst_fmt_reg);
        end
        else
        begin
            result = packed_pixel & fmt_mask(dst_fmt_reg);
        end
    end

    assign in_valid_next  = s_axis_tvalid ? 1'b1 : (in_valid_reg && !advance);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fmt_reg   <= FMT_Y1;
            dst_fmt_reg   <= FMT_Y1;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            src_fmt_reg <= src_fmt_next;
            dst_fmt_reg <= dst_fmt_next;
            if (s_axis_tready)
            begin
                in_valid_reg <= in_valid_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_pixel_reg <= s_axis_tdata;
        end
        if (advance && in_valid_reg)
        begin
            out_pixel_reg <= result;
        end
    end

`ifndef NO_ASSERTIONS
    a_out_from_input_reg: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_valid_reg))
        else $error("Output word appeared without a word in the input register.");

    a_input_reg_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_pixel_reg)))
        else $error("Input register changed while the output register was full.");

    a_dest_width: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata & ~fmt_mask(dst_fmt_reg)) == 32'd0))
        else $error("Output word has bits beyond the destination width.");

    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance && (src_fmt_reg > FMT_BGR || dst_fmt_reg > FMT_BGR))
        |=> (m_axis_tdata == 32'd0))
        else $error("Unknown format code did not give a zero word.");
`endif

endmodule

// ===== sim/pfc_pixel_check.sv =====
// Checker for the pixel format converter: follows the format writes, predicts
// each converted pixel and compares it with the output stream in order.
// Depends on pfc_pkg for the format codes, register indexes and the RGBA type.
module pfc_pixel_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    output int          mismatches,
    output int          pixels_out
);
    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    fmt_t        src_fmt;
    fmt_t        dst_fmt;
    logic [31:0] expected_pixels[$];
    logic [31:0] want;

    function automatic logic [23:0] cga_color(input logic [3:0] idx);
        logic [23:0] c;
        case (idx)
            4'd0:    c = 24'h000000;
            4'd1:    c = 24'h0000AA;
            4'd2:    c = 24'h00AA00;
            4'd3:    c = 24'h00AAAA;
            4'd4:    c = 24'hAA0000;
            4'd5:    c = 24'hAA00AA;
            4'd6:    c = 24'hAA5500;
            4'd7:    c = 24'hAAAAAA;
            4'd8:    c = 24'h555555;
            4'd9:    c = 24'h5555FF;
            4'd10:   c = 24'h55FF55;
            4'd11:   c = 24'h55FFFF;
            4'd12:   c = 24'hFF5555;
            4'd13:   c = 24'hFF55FF;
            4'd14:   c = 24'hFFFF55;
            default: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] format_mask(input fmt_t f);
        logic [31:0] m;
        case (f)
            FMT_Y1:                            m = 32'h0000_0001;
            FMT_Y2:                            m = 32'h0000_0003;
            FMT_Y4, FMT_CGA4:                  m = 32'h0000_000f;
            FMT_Y8, FMT_BGR332:                m = 32'h0000_00ff;
            FMT_Y16, FMT_XRGB4444, FMT_BGR565: m = 32'h0000_ffff;
            FMT_Y24, FMT_RGB, FMT_BGR:         m = 32'h00ff_ffff;
            default:                           m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    function automatic logic [9:0] channel_dist(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? {2'b00, a - b} : {2'b00, b - a};
    endfunction

    function automatic logic [3:0] nearest_cga_index(input rgba_t c);
        logic [9:0]  best_score;
        logic [9:0]  score;
        logic [3:0]  best;
        logic [23:0] e;
        best = 4'd0;
        best_score = 10'd768;
        for (int i = 0; i < 16; i++)
        begin
            e = cga_color(4'(i));
            score = channel_dist(e[23:16], c.r) + channel_dist(e[15:8], c.g)
                  + channel_dist(e[7:0], c.b);
            if (score < best_score)
            begin
                best = 4'(i);
                best_score = score;
            end
        end
        return best;
    endfunction

    function automatic rgba_t unpack_to_rgba(input fmt_t f, input logic [31:0] v);
        logic [7:0] y;
        rgba_t      c;
        case (f)
            FMT_Y1:       c = v[0] ? 32'hffff_ffff : 32'h0000_00ff;
            FMT_Y2:       begin y = {4{v[1:0]}}; c = {y, y, y, 8'hff}; end
            FMT_Y4:       begin y = {2{v[3:0]}}; c = {y, y, y, 8'hff}; end
            FMT_CGA4:     c = {cga_color(v[3:0]), 8'hff};
            FMT_Y8:       c = {v[7:0], v[7:0], v[7:0], 8'hff};
            FMT_BGR332:   c = {{4{v[1:0]}}, {v[4:2], v[4:2], v[4:3]},
                               {v[7:5], v[7:5], v[7:6]}, 8'hff};
            FMT_Y16:      c = {v[15:8], v[15:8], v[15:8], 8'hff};
            FMT_XRGB4444: c = {{2{v[11:8]}}, {2{v[7:4]}}, {2{v[3:0]}}, 8'hff};
            FMT_BGR565:   c = {{v[4:0], v[4:2]}, {v[10:5], v[10:9]},
                               {v[15:11], v[15:13]}, 8'hff};
            FMT_Y32:      c = {v[31:24], v[31:24], v[31:24], 8'hff};
            FMT_BGRX:     c = {v[15:8], v[23:16], v[31:24], 8'hff};
            FMT_XRGB, FMT_RGB: c = {v[23:16], v[15:8], v[7:0], 8'hff};
            FMT_XBGR, FMT_BGR: c = {v[7:0], v[15:8], v[23:16], 8'hff};
            FMT_Y24:      c = {v[23:16], v[23:16], v[23:16], 8'hff};
            default:      c = v;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] pack_from_rgba(input fmt_t f, input rgba_t c);
        logic [9:0]  sum;
        logic [7:0]  y;
        logic [31:0] p;
        sum = {2'b00, c.r} + {2'b00, c.g} + {2'b00, c.b};
        y = 8'(sum / 10'd3);
        case (f)
            FMT_Y1:       p = (sum >= 10'd384) ? 32'd1 : 32'd0;
            FMT_Y2:       p = {30'd0, y[7:6]};
            FMT_Y4:       p = {28'd0, y[7:4]};
            FMT_CGA4:     p = {28'd0, nearest_cga_index(c)};
            FMT_Y8:       p = {24'd0, y};
            FMT_BGR332:   p = {24'd0, c.b[7:5], c.g[7:5], c.r[7:6]};
            FMT_Y16:      p = {16'd0, y, y};
            FMT_XRGB4444: p = {16'd0, 4'hf, c.r[7:4], c.g[7:4], c.b[7:4]};
            FMT_BGR565:   p = {16'd0, c.b[7:3], c.g[7:2], c.r[7:3]};
            FMT_Y32:      p = {y, y, y, y};
            FMT_BGRX:     p = {c.b, c.g, c.r, 8'hff};
            FMT_XRGB, FMT_RGB: p = {8'd0, c.r, c.g, c.b};
            FMT_XBGR, FMT_BGR: p = {8'd0, c.b, c.g, c.r};
            FMT_Y24:      p = {8'd0, y, y, y};
            default:      p = c;
        endcase
        return p;
    endfunction

    function automatic logic [31:0] convert_pixel(input fmt_t sf, input fmt_t df,
                                                  input logic [31:0] px);
        logic [31:0] v;
        logic [31:0] res;
        if (sf > FMT_BGR || df > FMT_BGR)
            return 32'd0;
        v = px & format_mask(sf);
        if (sf == df)
            res = v;
        else
            res = pack_from_rgba(df, unpack_to_rgba(sf, v));
        return res & format_mask(df);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fmt = FMT_Y1;
            dst_fmt = FMT_Y1;
            expected_pixels.delete();
            mismatches <= 0;
            pixels_out <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SOURCE_FORMAT)
                    src_fmt = fmt_t'(cfg_data);
                else
                    dst_fmt = fmt_t'(cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_pixels.push_back(convert_pixel(src_fmt, dst_fmt, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                pixels_out <= pixels_out + 1;
                if (expected_pixels.size() == 0)
                begin
                    if (mismatches < 32)
                        $display("%0t: unexpected dst_pixel word, expected none, got %08h",
                                 $time, m_axis_tdata);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        if (mismatches < 32)
                            $display("%0t: dst_pixel mismatch, expected %08h, got %08h",
                                     $time, want, m_axis_tdata);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/pixel_format_converter_top_test.sv =====
// Top of the pixel format converter testbench: clock, reset, format writes,
// bursty pixel stimulus and a stalling receiver; gives the verdict.
// Depends on pfc_pkg, pixel_format_converter_top and pfc_pixel_check.
module pixel_format_converter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    localparam logic [4:0] FMT_UNKNOWN_LO = 5'd17;
    localparam logic [4:0] FMT_UNKNOWN_HI = 5'd31;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_SOURCE_FORMAT;
    logic [4:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    int          mismatches;
    int          pixels_out;

    int pixels_sent = 0;
    int burst_left = 0;
    int hold_requests = 0;

    pixel_format_converter_top dut (.*);

    pfc_pixel_check u_pixel_check (.*);

    always #5 clk = ~clk;

    initial
    begin
        #2ms;
        $display("pixel_format_converter_top_test: FAIL");
        $finish;
    end

    task automatic send_pixel(input logic [31:0] px);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        do @(posedge clk); while (!s_axis_tready);
        pixels_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 20);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pixels_out != pixels_sent) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [4:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_formats(input logic [4:0] src, input logic [4:0] dst);
        wait_drained();
        @(posedge clk);
        write_reg(REG_SOURCE_FORMAT, src);
        write_reg(REG_DEST_FORMAT, dst);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_pixel();
        logic [31:0] px;
        case ($urandom_range(0, 7))
            0:       px = 32'h0000_0000;
            1:       px = 32'hffff_ffff;
            2:       px = $urandom_range(0, 15);
            3:       px = $urandom_range(0, 255);
            4:       px = $urandom & 32'h0000_ffff;
            5:       px = $urandom & 32'h00ff_ffff;
            default: px = $urandom;
        endcase
        return px;
    endfunction

    initial
    begin
        int mode_left;
        int mode;
        mode_left = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests > 0)
            begin
                hold_requests--;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (mode_left % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    initial
    begin
        logic [4:0] src;
        logic [4:0] dst;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset formats are equal, so stray bits above bit 0 must be dropped.
        send_pixel(32'h0000_0000);
        send_pixel(32'h0000_0001);
        send_pixel(32'hffff_ffff);
        send_pixel(32'hffff_fffe);

        set_formats(FMT_RGBX, FMT_BGRX);
        send_pixel(32'h1234_5678);
        send_pixel(32'hffff_ffff);
        set_formats(FMT_BGR565, FMT_RGBX);
        send_pixel(32'h0000_f81f);
        send_pixel(32'hffff_07e0);

        // Pure blue at 0x55 sits halfway between black and dark blue.
        set_formats(FMT_RGB, FMT_CGA4);
        send_pixel(32'h0000_0055);
        send_pixel(32'h0080_8080);
        send_pixel(32'h00ff_ffff);
        send_pixel(32'h00aa_5500);
        send_pixel(32'hff7f_7f7f);

        set_formats(FMT_RGB, FMT_Y1);
        send_pixel(32'h0080_8080);
        send_pixel(32'h007f_8080);

        set_formats(FMT_UNKNOWN_LO, FMT_Y8);
        send_pixel(32'hdead_beef);
        set_formats(FMT_Y8, FMT_UNKNOWN_HI);
        send_pixel(32'h0000_00ff);
        set_formats(FMT_UNKNOWN_HI, FMT_UNKNOWN_HI);
        send_pixel(32'hffff_ffff);

        for (int p = 0; p < 50; p++)
        begin
            if (p <= FMT_BGR)
            begin
                src = 5'(p);
                dst = 5'($urandom_range(0, FMT_BGR));
            end
            else if (p <= 2 * FMT_BGR + 1)
            begin
                src = 5'($urandom_range(0, FMT_BGR));
                dst = 5'(p - FMT_BGR - 1);
            end
            else
            begin
                src = 5'($urandom_range(0, FMT_BGR));
                dst = ($urandom_range(0, 3) == 0) ? src : 5'($urandom_range(0, FMT_BGR));
                if ($urandom_range(0, 7) == 0)
                    src = 5'($urandom_range(FMT_UNKNOWN_LO, FMT_UNKNOWN_HI));
                if ($urandom_range(0, 7) == 0)
                    dst = 5'($urandom_range(FMT_UNKNOWN_LO, FMT_UNKNOWN_HI));
            end
            set_formats(src, dst);
            if (p == 20 || p == 40)
                hold_requests++;
            repeat (14) send_pixel(random_pixel());
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("pixel_format_converter_top_test: PASS");
        else
            $display("pixel_format_converter_top_test: FAIL");
        $finish;
    end

endmodule
